// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the parking gap detector RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising edge of clk_i, off during reset.
`define PGD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication form: when the trigger holds, the consequent holds in the next cycle.
`define PGD_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pgd_pkg.sv -----
// Package for the parking gap detector: field widths, register codes and reset values.
// Used by pgd_cfg, pgd_update and parking_gap_detector; depends on nothing.
package pgd_pkg;

  // Default width of the sample counter.
  localparam int unsigned IndexBitsDef = 16;

  // Field widths.
  localparam int unsigned DistW   = 8;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned RunW    = 16;
  localparam int unsigned EndXW   = 9;
  localparam int unsigned PosYW   = 16;
  localparam int unsigned CenterW = 7;
  localparam int unsigned LimitW  = 10;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_VEHICLE_W        = 2'd0,
    REG_CLEARANCE        = 2'd1,
    REG_LENGTH_THRESHOLD = 2'd2,
    REG_END_POINT_LAG    = 2'd3
  } pgd_reg_e;

  // Reset values of the configuration registers.
  localparam logic [CfgW-1:0] CarWidthRst        = 8'd180;
  localparam logic [CfgW-1:0] SafetyMarginRst    = 8'd20;
  localparam logic [CfgW-1:0] LengthThresholdRst = 8'd50;
  localparam logic [CfgW-1:0] EndPointLagRst     = 8'd10;

  // Configuration bundle handed from the register file to the update logic.
  typedef struct packed {
    logic [CfgW-1:0] vehicle_w;
    logic [CfgW-1:0] clearance;
    logic [CfgW-1:0] length_threshold;
    logic [CfgW-1:0] end_point_lag;
  } pgd_cfg_t;

  // One result item as held after the update.
  typedef struct packed {
    logic               space_found;
    logic [EndXW-1:0]   end_x;
    logic [PosYW-1:0]   end_y;
    logic [PosYW-1:0]   start_y;
    logic [CenterW-1:0] center_x;
    logic [CenterW-1:0] center_y;
  } pgd_result_t;

endpackage

// ----- hdl/pgd_cfg.sv -----
// Configuration register file of the parking gap detector.
// Depends on pgd_pkg for the register codes, reset values and the config bundle.
module pgd_cfg
  import pgd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  output pgd_cfg_t        cfg_o
);

  pgd_cfg_t cfg_q;
  pgd_reg_e reg_sel;

  assign reg_sel = pgd_reg_e'(cfg_idx_i);

  // Write one register per enabled cycle; the index decodes fully.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vehicle_w        <= CarWidthRst;
      cfg_q.clearance        <= SafetyMarginRst;
      cfg_q.length_threshold <= LengthThresholdRst;
      cfg_q.end_point_lag    <= EndPointLagRst;
    end else if (cfg_we_i) begin
      unique case (reg_sel)
        REG_VEHICLE_W:        cfg_q.vehicle_w        <= cfg_wdata_i;
        REG_CLEARANCE:        cfg_q.clearance        <= cfg_wdata_i;
        REG_LENGTH_THRESHOLD: cfg_q.length_threshold <= cfg_wdata_i;
        REG_END_POINT_LAG:    cfg_q.end_point_lag    <= cfg_wdata_i;
        default:              cfg_q                  <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/pgd_update.sv -----
// Per-sample update of the gap tracking state and the held result fields.
// Depends on pgd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pgd_update
  import pgd_pkg::*;
#(
  parameter int unsigned IndexBits = IndexBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [DistW-1:0] distance_i,
  input  pgd_cfg_t         cfg_i,
  output pgd_result_t      result_o
);

  localparam logic [IndexBits-1:0] IndexMax = '1;

  logic [DistW-1:0]     nbr_q, nbr_d;
  logic [RunW-1:0]      run_q, run_d;
  logic [IndexBits-1:0] idx_q, idx_d;
  pgd_result_t          res_q, res_d;

  logic [LimitW-1:0]          limit;
  logic                       deep;
  logic [RunW-1:0]            run_inc;
  logic [LimitW-1:0]          end_x_sum;
  logic [IndexBits+PosYW-1:0] idx_ext;
  logic [PosYW-1:0]           idx_low;
  logic [DistW-1:0]           gap_diff;
  logic                       found;

  // Depth test against car width, margin and the neighbour at full width.
  assign limit = LimitW'(cfg_i.vehicle_w) + LimitW'(cfg_i.clearance)
               + LimitW'(nbr_q);
  assign deep  = LimitW'(distance_i) > limit;

  // Saturating counters.
  assign idx_d   = (idx_q == IndexMax) ? idx_q : idx_q + 1'b1;
  assign run_inc = (run_q == '1) ? run_q : run_q + 1'b1;

  // The index is zero-extended before taking the low bits, so narrow counters work.
  assign idx_ext = {{PosYW{1'b0}}, idx_d};
  assign idx_low = idx_ext[PosYW-1:0];

  // End point x: half car width plus the neighbour minus half of it plus the sample.
  assign end_x_sum = LimitW'(cfg_i.vehicle_w[CfgW-1:1]) + LimitW'(nbr_q)
                   + LimitW'(distance_i) - LimitW'(nbr_q[DistW-1:1]);

  // Run, neighbour and end point.
  always_comb begin
    res_d = res_q;
    nbr_d = nbr_q;
    if (deep) begin
      run_d = run_inc;
      if (run_inc > RunW'(cfg_i.end_point_lag)) begin
        res_d.end_x = end_x_sum[EndXW-1:0];
        res_d.end_y = idx_low;
      end
    end else begin
      nbr_d       = distance_i;
      run_d       = '0;
      res_d.end_x = '0;
      res_d.end_y = '0;
    end

    // Start point and gap centre once the run is long enough.
    found             = run_d > RunW'(cfg_i.length_threshold);
    res_d.space_found = found;
    gap_diff          = distance_i - nbr_d;
    if (found) begin
      res_d.start_y  = idx_low;
      res_d.center_x = gap_diff[DistW-1:1];
      res_d.center_y = run_d[CenterW:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nbr_q <= '0;
      run_q <= '0;
      idx_q <= '0;
      res_q <= '0;
    end else if (step_i) begin
      nbr_q <= nbr_d;
      run_q <= run_d;
      idx_q <= idx_d;
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

  // An empty run never carries an end point.
  `PGD_ASSERT(a_run_zero_no_end, (run_q == '0) |-> (res_q.end_x == '0 && res_q.end_y == '0),
              "end point held without a run")
  // A shallow sample becomes the neighbour and clears the run.
  `PGD_ASSERT_NEXT(a_shallow_clears, step_i && !deep,
                   run_q == '0 && nbr_q == $past(distance_i),
                   "shallow sample did not reset the run")
  // The sample counter never wraps.
  `PGD_ASSERT_NEXT(a_index_no_wrap, step_i, idx_q >= $past(idx_q),
                   "sample index wrapped")

endmodule

// ----- hdl/parking_gap_detector.sv -----
// A sample passes through the input register, then the result register, before its result is valid.
// One sample per cycle unless stalled; the state update is a single add-and-compare pass.
// While a result is stalled, one sample waits in the input register and further input is held.
// Reset (rst_ni low, asynchronous) clears the tracking state and held fields to zero
// and loads the configuration defaults: width 180, margin 20, threshold 50, lag 10.
module parking_gap_detector
  import pgd_pkg::*;
#(
  parameter int unsigned IndexBits = IndexBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [DistW-1:0]   distance_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               space_found_o,
  output logic [EndXW-1:0]   end_x_o,
  output logic [PosYW-1:0]   end_y_o,
  output logic [PosYW-1:0]   start_y_o,
  output logic [CenterW-1:0] center_x_o,
  output logic [CenterW-1:0] center_y_o
);

  pgd_cfg_t         cfg;
  pgd_result_t      result;
  logic             in_vld_q;
  logic [DistW-1:0] dist_q;
  logic             out_vld_q;
  logic             advance;

  // An item moves from the input register into the result when the output slot is free.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      dist_q <= distance_i;
    end
  end

  // Result valid flag; the payload lives in the update block's registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  pgd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pgd_update #(
    .IndexBits (IndexBits)
  ) u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .distance_i (dist_q),
    .cfg_i      (cfg),
    .result_o   (result)
  );

  assign out_valid_o   = out_vld_q;
  assign space_found_o = result.space_found;
  assign end_x_o       = result.end_x;
  assign end_y_o       = result.end_y;
  assign start_y_o     = result.start_y;
  assign center_x_o    = result.center_x;
  assign center_y_o    = result.center_y;

endmodule
